// ===== design/gray_forward_gradient_edge_assert.svh =====
// Assertion macros for the gray/edge block.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef GRAY_FORWARD_GRADIENT_EDGE_ASSERT_SVH
`define GRAY_FORWARD_GRADIENT_EDGE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define GFG_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gfg assertion failed");

// Next-cycle implication.
`define GFG_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gfg assertion failed");

`else

`define GFG_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define GFG_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== design/gfg_pkg.sv =====
`timescale 1ns / 1ps

package gfg_pkg;

    localparam int PIX_W          = 8;
    localparam int LINE_WIDTH_W   = 12;
    localparam int DEFAULT_MAX_WIDTH = 2048;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd640;
    localparam logic [LINE_WIDTH_W-1:0] MIN_WIDTH        = 12'd2;

    // Q16 luminance weights
    localparam int GRAY_PROD_W = 24;
    localparam logic [15:0] GRAY_WEIGHT_R = 16'd13763;
    localparam logic [15:0] GRAY_WEIGHT_G = 16'd47186;
    localparam logic [15:0] GRAY_WEIGHT_B = 16'd4588;

    // gradient square sum and root
    localparam int SQ_W       = 17;
    localparam int SQRT_STEPS = 8;
    localparam int STEP_W     = $clog2(SQRT_STEPS);
    localparam logic [SQ_W-1:0]  SQRT_SAT_LIMIT = 17'd65025;
    localparam logic [PIX_W-1:0] EDGE_SAT       = 8'd255;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_LINE_WIDTH = 1'b0;   // word index, paddr[2]

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_SQ,
        S_START,
        S_ROOT,
        S_OUT
    } state_t;

endpackage

// ===== design/gfg_line_mem.sv =====
`timescale 1ns / 1ps

module gfg_line_mem #(
    parameter int MAX_WIDTH = gfg_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
    input  logic [gfg_pkg::PIX_W-1:0]          wr_data,
    input  logic                               rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]       rd_addr_a,
    input  logic [$clog2(MAX_WIDTH)-1:0]       rd_addr_b,
    output logic [gfg_pkg::PIX_W-1:0]          rd_data_a,
    output logic [gfg_pkg::PIX_W-1:0]          rd_data_b
);
    import gfg_pkg::*;

    logic [PIX_W-1:0] mem [MAX_WIDTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== design/gfg_isqrt.sv =====
`timescale 1ns / 1ps

module gfg_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gfg_pkg::SQ_W-1:0]      value,
    output logic                          done,
    output logic [gfg_pkg::PIX_W-1:0]     root
);
    import gfg_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SQ_W-1:0]   rem_reg, rem_next;
    logic [SQ_W-1:0]   acc_reg, acc_next;
    logic [SQ_W-1:0]   bit_val;
    logic [SQ_W-1:0]   trial;

    assign bit_val = SQ_W'(1) << {step_reg, 1'b0};
    assign trial   = acc_reg + bit_val;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            rem_next  = value;
            step_next = STEP_W'(SQRT_STEPS - 1);
            if (value >= SQRT_SAT_LIMIT)
            begin
                // clamp: skip the iterations
                acc_next  = SQ_W'(EDGE_SAT);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next  = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            // one result bit per cycle
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                acc_next = (acc_reg >> 1) + bit_val;
            end
            else
            begin
                acc_next = acc_reg >> 1;
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign root = acc_reg[PIX_W-1:0];

endmodule

// ===== design/gray_forward_gradient_edge.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_ready   red, green, blue, frame_start
// out       out_valid / out_ready gray_value, edge_value, edge_valid
// cfg       APB write/read        line_width at byte address 0
//
// One pixel is in flight at a time: it passes MUL, SUM, SQ, START, ROOT and
// OUT before the result word loads, and the next word can be taken in the
// cycle after; the eight-step root unit dominates unless the sum saturates.
// Reset clears the sequencer, pixel count, write slot and line_width (640);
// the line memory is not cleared. A full output register holds the sequencer
// in its last state until out_ready; input is taken again once it is free.

module gray_forward_gradient_edge #(
    parameter int MAX_WIDTH = gfg_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // pixel input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [gfg_pkg::PIX_W-1:0]         red,
    input  logic [gfg_pkg::PIX_W-1:0]         green,
    input  logic [gfg_pkg::PIX_W-1:0]         blue,
    input  logic                              frame_start,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [gfg_pkg::PIX_W-1:0]         gray_value,
    output logic [gfg_pkg::PIX_W-1:0]         edge_value,
    output logic                              edge_valid,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gfg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [gfg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [gfg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import gfg_pkg::*;

`include "gray_forward_gradient_edge_assert.svh"

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic [CNT_W-1:0]        eff_width;
    logic                    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_LINE_WIDTH);
    assign prdata    = (paddr[2] == REG_LINE_WIDTH) ? APB_DATA_W'(line_width_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            line_width_reg <= pwdata[LINE_WIDTH_W-1:0];
        end
    end

    // clamp the row length into the range the line memory supports
    always_comb
    begin
        priority if (line_width_reg < MIN_WIDTH)
        begin
            eff_width = CNT_W'(MIN_WIDTH);
        end
        else if (32'(line_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_width = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = CNT_W'(line_width_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic   in_accept;
    logic   mem_rd_en;
    logic   mem_wr_en;
    logic   root_start;
    logic   root_done;
    logic   out_load;

    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        mem_rd_en  = 1'b0;
        mem_wr_en  = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // fetch the stored pixel and its right neighbour
                mem_rd_en  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // the new gray value replaces the pixel one row up
                mem_wr_en  = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                root_start = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Pixel position: count and circular write slot, updated on acceptance
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  pixel_count_reg, pixel_count_next;
    logic [ADDR_W-1:0] write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]  count_cur;
    logic [CNT_W-1:0]  slot_cur;
    logic [CNT_W-1:0]  slot_plus;
    logic [CNT_W-1:0]  slot_after;
    logic [ADDR_W-1:0] slot_reg;
    logic [ADDR_W-1:0] right_reg;
    logic              have_edge_reg;

    always_comb
    begin
        if (frame_start)
        begin
            count_cur = '0;
            slot_cur  = '0;
        end
        else
        begin
            count_cur = pixel_count_reg;
            // restart the slot if the row got shorter
            slot_cur  = (CNT_W'(write_slot_reg) >= eff_width) ? '0 : CNT_W'(write_slot_reg);
        end
        slot_plus  = slot_cur + CNT_W'(1);
        slot_after = (slot_plus >= eff_width) ? '0 : slot_plus;

        write_slot_next  = slot_after[ADDR_W-1:0];
        pixel_count_next = (count_cur < eff_width) ? count_cur + CNT_W'(1) : count_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= '0;
            write_slot_reg  <= '0;
        end
        else if (in_accept)
        begin
            pixel_count_reg <= pixel_count_next;
            write_slot_reg  <= write_slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]       red_reg, green_reg, blue_reg;
    logic [GRAY_PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [GRAY_PROD_W-1:0] gray_sum;
    logic [PIX_W-1:0]       gray_new;
    logic [PIX_W-1:0]       gray_reg;
    logic [PIX_W-1:0]       here_data;
    logic [PIX_W-1:0]       right_data;
    logic signed [PIX_W:0]  dx_reg, dy_reg;
    logic signed [2*PIX_W+1:0] sq_x, sq_y;
    logic [SQ_W-1:0]        sq_sum_reg;
    logic [PIX_W-1:0]       root;

    assign gray_sum = prod_r_reg + prod_g_reg + prod_b_reg;
    assign gray_new = gray_sum[GRAY_PROD_W-1:GRAY_PROD_W-PIX_W];
    assign sq_x     = dx_reg * dx_reg;
    assign sq_y     = dy_reg * dy_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            red_reg       <= red;
            green_reg     <= green;
            blue_reg      <= blue;
            slot_reg      <= slot_cur[ADDR_W-1:0];
            right_reg     <= slot_after[ADDR_W-1:0];
            have_edge_reg <= (count_cur >= eff_width);
        end
        if (state_reg == S_MUL)
        begin
            prod_r_reg <= GRAY_PROD_W'(red_reg) * GRAY_PROD_W'(GRAY_WEIGHT_R);
            prod_g_reg <= GRAY_PROD_W'(green_reg) * GRAY_PROD_W'(GRAY_WEIGHT_G);
            prod_b_reg <= GRAY_PROD_W'(blue_reg) * GRAY_PROD_W'(GRAY_WEIGHT_B);
        end
        if (state_reg == S_SUM)
        begin
            gray_reg <= gray_new;
            dx_reg   <= $signed({1'b0, here_data}) - $signed({1'b0, gray_new});
            dy_reg   <= $signed({1'b0, here_data}) - $signed({1'b0, right_data});
        end
        if (state_reg == S_SQ)
        begin
            // each square is at most 255*255, sixteen bits
            sq_sum_reg <= {1'b0, sq_x[2*PIX_W-1:0]} + {1'b0, sq_y[2*PIX_W-1:0]};
        end
    end

    // Reads and the write of one pixel fall in different states, so no
    // access to an entry can overlap another one.
    gfg_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (slot_reg),
        .wr_data   (gray_new),
        .rd_en     (mem_rd_en),
        .rd_addr_a (slot_reg),
        .rd_addr_b (right_reg),
        .rd_data_a (here_data),
        .rd_data_b (right_data)
    );

    gfg_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (sq_sum_reg),
        .done  (root_done),
        .root  (root)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] gray_out_reg;
    logic [PIX_W-1:0] edge_out_reg;
    logic             edge_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            gray_out_reg   <= gray_reg;
            edge_out_reg   <= have_edge_reg ? root : '0;
            edge_valid_reg <= have_edge_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gray_value = gray_out_reg;
    assign edge_value = edge_out_reg;
    assign edge_valid = edge_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GFG_ASSERT_NEXT(a_accept_starts_fetch, clk, rst_n, in_accept, state_reg == S_MUL)
    `GFG_ASSERT_IMPLY(a_root_done_in_wait, clk, rst_n, root_done, state_reg == S_ROOT)
    `GFG_ASSERT_IMPLY(a_no_edge_is_zero, clk, rst_n, out_valid && !edge_valid, edge_value == '0)
    `GFG_ASSERT_IMPLY(a_no_load_over_full, clk, rst_n, out_load && out_valid_reg, out_ready)

endmodule
